// ----- src/vrbm_pkg.sv -----
// Shared types, constants and register indexes for the variable radius box mean block.
`timescale 1ns / 1ps
package vrbm_pkg;

  // Default geometry, handed to the top level as parameter defaults
  localparam int unsigned MAX_ROWS_DEF   = 64;
  localparam int unsigned MAX_COLS_DEF   = 64;
  localparam int unsigned NUM_PARTS_DEF  = 4;
  localparam int unsigned MAX_RADIUS_DEF = 7;

  // Coordinate arithmetic width: covers the largest grid and centre plus radius
  localparam int unsigned GRID_W = 11;

  localparam int unsigned VAL_W  = 8;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned Q_W    = 24;   // quotient bits of the mean
  localparam int unsigned CNT_OUT_W = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned RAD_REG_W  = 3;
  localparam int unsigned NUM_RAD_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_THREE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_FOUR   = 3'd5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] cell_value;
    logic [2:0] part_label;
  } in_t;

  typedef struct packed {
    logic [23:0] mean_q16;
    logic [7:0]  used_count;
  } out_t;

endpackage

// ----- src/vrbm_ram.sv -----
// Generic simple dual-port RAM with one registered read port.
`timescale 1ns / 1ps
module vrbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/vrbm_div.sv -----
// Radix-2 restoring divider for the window mean: (sum << 16) / count, 24 quotient bits.
`timescale 1ns / 1ps
module vrbm_div #(
  parameter int unsigned CNT_W = 8,
  localparam int unsigned SUM_W = CNT_W + vrbm_pkg::VAL_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [SUM_W-1:0]        sum_i,
  input  logic [CNT_W-1:0]        den_i,
  output logic                    done_o,
  output logic [vrbm_pkg::Q_W-1:0] quot_o
);
  import vrbm_pkg::*;

  localparam int unsigned IT_W = $clog2(Q_W);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [IT_W-1:0]  it_q, it_d;
  logic [CNT_W:0]   rem_q, rem_d;
  logic [Q_W-1:0]   sh_q, sh_d;
  logic [CNT_W-1:0] den_q, den_d;
  logic [CNT_W:0]   trial;
  logic             qbit;

  // The mean never exceeds 255.0, so sum >> 8 is already below the count and
  // only the low 24 dividend bits need a step each.
  always_comb begin
    trial  = {rem_q[CNT_W-1:0], sh_q[Q_W-1]};
    qbit   = (trial >= {1'b0, den_q});
    run_d  = run_q;
    done_d = 1'b0;
    it_d   = it_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      it_d  = '0;
      rem_d = {1'b0, sum_i[SUM_W-1:VAL_W]};
      sh_d  = {sum_i[VAL_W-1:0], {FRAC_W{1'b0}}};
      den_d = den_i;
    end else if (run_q) begin
      rem_d = qbit ? (trial - {1'b0, den_q}) : trial;
      sh_d  = {sh_q[Q_W-2:0], qbit};
      it_d  = it_q + 1'b1;
      if (it_q == IT_W'(Q_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

// ----- src/variable_radius_box_mean.sv -----
// Top level of the variable radius box mean block: grid store, window walk and mean.
//
// Usage: an item is taken when start is high and busy is low. A write item
// (kind 0) stores one cell's value and partition label and gives no result;
// busy stays low, so items may follow every cycle. A query item (kind 1) on
// a cell inside the grid in use reads the cell's label, takes the radius
// register of its partition and then reads each in-grid cell of the clipped
// window from the cell memory, one per cycle. A 24-step divider then forms
// the mean. The result is on res_o with res_strobe_o high for exactly one
// cycle, then held; busy is high from taking the query until the strobe. The
// clipped window holds at most 225 cells with the defaults. A query outside
// the grid gives no result and does not raise busy. The receiver cannot
// stall; each result is taken in its strobe cycle. Configuration writes are
// always ready; the user must make them while idle, as the block itself
// does not enforce it. Reset restores the register defaults; the cell
// memory is not cleared and a cell must be written before any query reads it.
`timescale 1ns / 1ps
module variable_radius_box_mean #(
  parameter int unsigned MAX_ROWS   = vrbm_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS   = vrbm_pkg::MAX_COLS_DEF,
  parameter int unsigned NUM_PARTS  = vrbm_pkg::NUM_PARTS_DEF,
  parameter int unsigned MAX_RADIUS = vrbm_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  vrbm_pkg::in_t                   item_i,
  output logic                            res_strobe_o,
  output vrbm_pkg::out_t                  res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vrbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vrbm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import vrbm_pkg::*;

  localparam int unsigned CELLS  = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned LBL_W  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int unsigned DW     = VAL_W + LBL_W;
  localparam int unsigned WIN    = 2 * MAX_RADIUS + 1;
  localparam int unsigned CNT_W  = $clog2(WIN * WIN + 1);
  localparam int unsigned SUM_W  = CNT_W + VAL_W;
  localparam int unsigned PROD_W = 2 * GRID_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LABEL = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DIV   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CFG_DATA_W-1:0] rows_q, cols_q;
  logic [RAD_REG_W-1:0]  rad_q [NUM_RAD_REGS];

  logic [GRID_W-1:0] nr, nc, row_ext, col_ext;
  logic              accept, in_grid, wr_ok, q_go;

  // Cell memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [PROD_W-1:0] in_addr_full, walk_addr_full;
  logic [2:0]        part_raw;
  logic [LBL_W-1:0]  part_lbl;

  // Window walk
  logic [5:0]        q_row_q, q_col_q;
  logic [GRID_W-1:0] r_q, r_d, c_q, c_d;
  logic [GRID_W-1:0] r0_q, r0_d, r1_q, r1_d, c0_q, c0_d, c1_q, c1_d;
  logic [GRID_W-1:0] qrow_ext, qcol_ext, rad, rad_raw, r_hi, c_hi;
  logic [3:0]        lbl4;
  logic              pend_q, pend_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  // Divider and result
  logic            div_start, div_done;
  logic [Q_W-1:0]  div_quot;
  logic            strobe_q, strobe_d;
  out_t            res_q;

  assign nr = (GRID_W'(rows_q) > GRID_W'(MAX_ROWS)) ? GRID_W'(MAX_ROWS) : GRID_W'(rows_q);
  assign nc = (GRID_W'(cols_q) > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS) : GRID_W'(cols_q);

  assign row_ext = GRID_W'(item_i.row);
  assign col_ext = GRID_W'(item_i.col);
  assign accept  = start && !busy;
  assign in_grid = (row_ext < nr) && (col_ext < nc);
  assign wr_ok   = (row_ext < GRID_W'(MAX_ROWS)) && (col_ext < GRID_W'(MAX_COLS));
  assign q_go    = accept && (item_i.kind == KIND_QUERY) && in_grid;

  // Label 0 wraps to the last partition
  assign part_raw = item_i.part_label - 3'd1;
  assign part_lbl = ({1'b0, part_raw} > 4'(NUM_PARTS - 1)) ? LBL_W'(NUM_PARTS - 1)
                                                            : LBL_W'(part_raw);

  assign in_addr_full   = PROD_W'(row_ext) * PROD_W'(MAX_COLS) + PROD_W'(col_ext);
  assign walk_addr_full = PROD_W'(r_q) * PROD_W'(MAX_COLS) + PROD_W'(c_q);

  assign ram_we    = accept && (item_i.kind == KIND_WRITE) && wr_ok;
  assign ram_waddr = in_addr_full[AW-1:0];
  assign ram_wdata = {item_i.cell_value, part_lbl};
  assign ram_raddr = (state_q == ST_IDLE) ? in_addr_full[AW-1:0] : walk_addr_full[AW-1:0];

  vrbm_ram #(
    .WIDTH (DW),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Radius of the centre cell; partitions without a register get radius 0
  assign lbl4     = 4'(ram_rdata[LBL_W-1:0]);
  assign rad_raw  = (lbl4 < 4'(NUM_RAD_REGS)) ? GRID_W'(rad_q[lbl4[1:0]]) : '0;
  assign rad      = (rad_raw > GRID_W'(MAX_RADIUS)) ? GRID_W'(MAX_RADIUS) : rad_raw;
  assign qrow_ext = GRID_W'(q_row_q);
  assign qcol_ext = GRID_W'(q_col_q);
  assign r_hi     = qrow_ext + rad;
  assign c_hi     = qcol_ext + rad;

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    c_d       = c_q;
    r0_d      = r0_q;
    r1_d      = r1_q;
    c0_d      = c0_q;
    c1_d      = c1_q;
    pend_d    = 1'b0;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    strobe_d  = 1'b0;
    div_start = 1'b0;

    // Data of the read issued in the previous walk cycle
    if (pend_q) begin
      sum_d = sum_q + SUM_W'(ram_rdata[DW-1:LBL_W]);
      cnt_d = cnt_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_go) begin
          state_d = ST_LABEL;
        end
      end
      ST_LABEL: begin
        r0_d    = (qrow_ext >= rad) ? (qrow_ext - rad) : '0;
        c0_d    = (qcol_ext >= rad) ? (qcol_ext - rad) : '0;
        r1_d    = (r_hi > (nr - 1'b1)) ? (nr - 1'b1) : r_hi;
        c1_d    = (c_hi > (nc - 1'b1)) ? (nc - 1'b1) : c_hi;
        r_d     = r0_d;
        c_d     = c0_d;
        sum_d   = '0;
        cnt_d   = '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        pend_d = 1'b1;
        if (c_q == c1_q) begin
          c_d = c0_q;
          r_d = r_q + 1'b1;
          if (r_q == r1_q) begin
            state_d = ST_DRAIN;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  vrbm_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_d),
    .den_i   (cnt_d),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
      rows_q   <= CFG_DATA_W'(64);
      cols_q   <= CFG_DATA_W'(64);
      for (int i = 0; i < NUM_RAD_REGS; i++) begin
        rad_q[i] <= RAD_REG_W'(1);
      end
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ROWS:      rows_q   <= cfg_data_i;
          REG_COLS:      cols_q   <= cfg_data_i;
          REG_RAD_ONE:   rad_q[0] <= cfg_data_i[RAD_REG_W-1:0];
          REG_RAD_TWO:   rad_q[1] <= cfg_data_i[RAD_REG_W-1:0];
          REG_RAD_THREE: rad_q[2] <= cfg_data_i[RAD_REG_W-1:0];
          REG_RAD_FOUR:  rad_q[3] <= cfg_data_i[RAD_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cnt_wide = (CNT_W + CNT_OUT_W)'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (q_go) begin
      q_row_q <= item_i.row;
      q_col_q <= item_i.col;
    end
    r_q   <= r_d;
    c_q   <= c_d;
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    c0_q  <= c0_d;
    c1_q  <= c1_d;
    sum_q <= sum_d;
    cnt_q <= cnt_d;
    if (strobe_d) begin
      res_q.mean_q16   <= div_quot;
      res_q.used_count <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

`ifndef SYNTHESIS
  a_strobe_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("result strobe without a query in flight");

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("result strobe held for more than one cycle");

  a_no_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !busy)
    else $error("cell memory written during a window walk");

  a_walk_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (r_q >= r0_q) && (r_q <= r1_q) && (c_q >= c0_q) && (c_q <= c1_q))
    else $error("window walk left the clipped window");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (cnt_d != '0))
    else $error("divider started with an empty window");
`endif

endmodule

// ----- test/tb.sv -----
// Testbench for variable_radius_box_mean: grid fill, directed window checks and random traffic.
`timescale 1ns / 1ps
module tb;
  import vrbm_pkg::*;

  localparam int unsigned GRID_ROWS     = MAX_ROWS_DEF;
  localparam int unsigned GRID_COLS     = MAX_COLS_DEF;
  localparam int unsigned RADIUS_CAP    = MAX_RADIUS_DEF;
  localparam int unsigned LAST_PART     = NUM_PARTS_DEF - 1;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned ITEMS_PER_SET = 140;
  // full-window queries behind the longest sender gaps for every item, with margin
  localparam longint unsigned CYCLE_LIMIT = 15000000;

  // indexes beyond the register file, writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_t                   item = '0;
  logic                  res_strobe;
  out_t                  res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the grid and registers
  logic [7:0]  cell_vals  [GRID_ROWS*GRID_COLS];
  logic [1:0]  cell_parts [GRID_ROWS*GRID_COLS];
  logic [6:0]  rows_reg;
  logic [6:0]  cols_reg;
  logic [2:0]  radius_reg [NUM_RAD_REGS];

  out_t            expected_means[$];
  out_t            want;
  int unsigned     fail_count = 0;
  int unsigned     sender_idle_pct = 0;
  longint unsigned cycle_count = 0;

  variable_radius_box_mean dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .item_i       (item),
    .res_strobe_o (res_strobe),
    .res_o        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned rows_active();
    return (rows_reg > GRID_ROWS) ? GRID_ROWS : rows_reg;
  endfunction

  function automatic int unsigned cols_active();
    return (cols_reg > GRID_COLS) ? GRID_COLS : cols_reg;
  endfunction

  function automatic in_t make_item(input logic kind, input logic [5:0] row,
                                    input logic [5:0] col, input logic [7:0] val,
                                    input logic [2:0] label);
    in_t it;
    it.kind       = kind;
    it.row        = row;
    it.col        = col;
    it.cell_value = val;
    it.part_label = label;
    return it;
  endfunction

  // Updates the shadow grid on a write, queues the window mean on a query inside the grid in use
  task automatic apply_item(input in_t it);
    int unsigned nr, nc, part, rad, idx, r0, r1, c0, c1;
    longint unsigned sum, cnt;
    out_t mean;
    nr  = rows_active();
    nc  = cols_active();
    idx = it.row * GRID_COLS + it.col;
    if (it.kind == KIND_WRITE) begin
      // label 0 wraps to the top index, anything past the last partition saturates
      part = (int'(it.part_label) + 7) % 8;
      if (part > LAST_PART) part = LAST_PART;
      cell_vals[idx]  = it.cell_value;
      cell_parts[idx] = part[1:0];
    end else if (it.row < nr && it.col < nc) begin
      part = cell_parts[idx];
      rad  = (part < NUM_RAD_REGS) ? radius_reg[part] : 0;
      if (rad > RADIUS_CAP) rad = RADIUS_CAP;
      r0 = (it.row >= rad) ? it.row - rad : 0;
      c0 = (it.col >= rad) ? it.col - rad : 0;
      r1 = (it.row + rad > nr - 1) ? nr - 1 : it.row + rad;
      c1 = (it.col + rad > nc - 1) ? nc - 1 : it.col + rad;
      sum = 0;
      cnt = 0;
      for (int unsigned r = r0; r <= r1; r++) begin
        for (int unsigned c = c0; c <= c1; c++) begin
          sum += cell_vals[r * GRID_COLS + c];
          cnt++;
        end
      end
      mean.mean_q16   = 24'((sum << 16) / cnt);
      mean.used_count = 8'(cnt);
      expected_means.push_back(mean);
    end
  endtask

  // start is left high on return, the next call either reuses it or idles first
  task automatic send_item(input in_t it);
    int unsigned gap;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(260, 1) : $urandom_range(3, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    apply_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  // writes give no result, so after the drain the bench also idles before going on
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROWS:      rows_reg = data;
      REG_COLS:      cols_reg = data;
      REG_RAD_ONE:   radius_reg[0] = data[2:0];
      REG_RAD_TWO:   radius_reg[1] = data[2:0];
      REG_RAD_THREE: radius_reg[2] = data[2:0];
      REG_RAD_FOUR:  radius_reg[3] = data[2:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [2:0] pick_label();
    return ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
  endfunction

  function automatic logic [7:0] pick_value();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Every cell gets a value first so no window ever reads an unwritten cell
  task automatic test_fill_grid();
    for (int unsigned r = 0; r < GRID_ROWS; r++) begin
      for (int unsigned c = 0; c < GRID_COLS; c++) begin
        send_item(make_item(KIND_WRITE, 6'(r), 6'(c), pick_value(), pick_label()));
      end
    end
    settle();
  endtask

  task automatic test_directed_windows();
    write_reg(REG_RAD_ONE, 7'd7);
    write_reg(REG_RAD_TWO, 7'd0);
    write_reg(REG_RAD_THREE, 7'd3);
    write_reg(REG_RAD_FOUR, 7'd7);
    write_reg(REG_SPARE_A, 7'($urandom));
    write_reg(REG_SPARE_B, 7'($urandom));
    // single-cell window at both value extremes
    send_item(make_item(KIND_WRITE, 6'd10, 6'd10, 8'hFF, 3'd2));
    send_item(make_item(KIND_QUERY, 6'd10, 6'd10, 8'($urandom), 3'($urandom)));
    send_item(make_item(KIND_WRITE, 6'd10, 6'd10, 8'h00, 3'd2));
    send_item(make_item(KIND_QUERY, 6'd10, 6'd10, 8'($urandom), 3'($urandom)));
    // corners clipped at the largest radius, then a centre at radius 3; labels 0 and 5..7 fold to the last partition
    send_item(make_item(KIND_WRITE, 6'd0, 6'd0, 8'hA5, 3'd1));
    send_item(make_item(KIND_QUERY, 6'd0, 6'd0, 8'h00, 3'd0));
    send_item(make_item(KIND_WRITE, 6'd63, 6'd63, 8'h5A, 3'd0));
    send_item(make_item(KIND_QUERY, 6'd63, 6'd63, 8'hFF, 3'd7));
    send_item(make_item(KIND_WRITE, 6'd0, 6'd63, 8'hFF, 3'd5));
    send_item(make_item(KIND_QUERY, 6'd0, 6'd63, 8'h00, 3'd0));
    send_item(make_item(KIND_WRITE, 6'd63, 6'd0, 8'h01, 3'd7));
    send_item(make_item(KIND_QUERY, 6'd63, 6'd0, 8'h00, 3'd0));
    send_item(make_item(KIND_WRITE, 6'd32, 6'd32, 8'h80, 3'd3));
    send_item(make_item(KIND_QUERY, 6'd32, 6'd32, 8'h00, 3'd0));
    // full 15x15 window
    send_item(make_item(KIND_WRITE, 6'd31, 6'd31, 8'h7F, 3'd6));
    send_item(make_item(KIND_QUERY, 6'd31, 6'd31, 8'h00, 3'd0));
    settle();
    // rows saturate, columns cut to five; centres off the grid give nothing
    write_reg(REG_ROWS, 7'd127);
    write_reg(REG_COLS, 7'd5);
    send_item(make_item(KIND_QUERY, 6'd63, 6'd4, 8'h00, 3'd0));
    send_item(make_item(KIND_QUERY, 6'd0, 6'd5, 8'h00, 3'd0));
    send_item(make_item(KIND_QUERY, 6'd63, 6'd63, 8'h00, 3'd0));
    settle();
    write_reg(REG_ROWS, 7'd0);
    send_item(make_item(KIND_QUERY, 6'd0, 6'd0, 8'h00, 3'd0));
    settle();
    write_reg(REG_ROWS, 7'd1);
    write_reg(REG_COLS, 7'd1);
    send_item(make_item(KIND_QUERY, 6'd0, 6'd0, 8'h00, 3'd0));
    send_item(make_item(KIND_QUERY, 6'd0, 6'd1, 8'h00, 3'd0));
    settle();
  endtask

  function automatic logic [6:0] pick_extent();
    case ($urandom_range(9))
      0:       return 7'($urandom_range(127, 65));
      1:       return 7'd64;
      2:       return 7'($urandom_range(4, 1));
      default: return 7'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic logic [6:0] pick_radius();
    // upper data bits are dropped by the radius registers
    return ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(7));
  endfunction

  task automatic program_setting(input int unsigned k);
    logic [6:0] nr, nc;
    logic [6:0] rad [NUM_RAD_REGS];
    nr = pick_extent();
    nc = pick_extent();
    for (int i = 0; i < NUM_RAD_REGS; i++) rad[i] = pick_radius();
    case (k)
      0: begin
        nr = 7'd64; nc = 7'd64;
        for (int i = 0; i < NUM_RAD_REGS; i++) rad[i] = 7'd7;
      end
      1: begin
        nr = 7'd1; nc = 7'd1;
      end
      2: begin
        nr = 7'd127; nc = 7'd127;
        for (int i = 0; i < NUM_RAD_REGS; i++) rad[i] = 7'd0;
      end
      3: nr = 7'd0;
      4: begin
        nr = 7'd64; nc = 7'd1;
      end
      default: ;
    endcase
    write_reg(REG_ROWS, nr);
    write_reg(REG_COLS, nc);
    write_reg(REG_RAD_ONE, rad[0]);
    write_reg(REG_RAD_TWO, rad[1]);
    write_reg(REG_RAD_THREE, rad[2]);
    write_reg(REG_RAD_FOUR, rad[3]);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_A, 7'($urandom));
  endtask

  task automatic test_random_traffic();
    int unsigned idle_pct [3];
    int unsigned setting, nr, nc;
    logic [5:0]  row, col;
    idle_pct[0] = 34;
    idle_pct[1] = 85;
    idle_pct[2] = 0;
    setting = 0;
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_pct[ph];
      for (int s = 0; s < 4; s++) begin
        settle();
        program_setting(setting);
        setting++;
        nr = rows_active();
        nc = cols_active();
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          if (n == ITEMS_PER_SET / 2 && s == 1) drain();
          if ($urandom_range(1) == 0) begin
            send_item(make_item(KIND_WRITE, 6'($urandom), 6'($urandom), pick_value(),
                                pick_label()));
          end else begin
            // mostly centres inside the grid in use, some anywhere
            row = (nr > 0 && $urandom_range(9) != 0) ? 6'($urandom_range(nr - 1))
                                                      : 6'($urandom);
            col = (nc > 0 && $urandom_range(9) != 0) ? 6'($urandom_range(nc - 1))
                                                      : 6'($urandom);
            send_item(make_item(KIND_QUERY, row, col, 8'($urandom), 3'($urandom)));
          end
        end
      end
    end
  endtask

  // each result transaction is taken in its strobe cycle
  always @(posedge clk) begin
    if (rst_n && res_strobe) begin
      if (expected_means.size() == 0) begin
        $display("%0t: result with none expected: mean_q16=%0d used_count=%0d",
                 $time, res.mean_q16, res.used_count);
        fail_count++;
      end else begin
        want = expected_means.pop_front();
        if (res.mean_q16 !== want.mean_q16) begin
          $display("%0t: mean_q16 mismatch: expected %0d, actual %0d",
                   $time, want.mean_q16, res.mean_q16);
          fail_count++;
        end
        if (res.used_count !== want.used_count) begin
          $display("%0t: used_count mismatch: expected %0d, actual %0d",
                   $time, want.used_count, res.used_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    for (int i = 0; i < NUM_RAD_REGS; i++) radius_reg[i] = 3'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 34;
    test_fill_grid();
    test_directed_windows();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/vrbm_pkg.sv
src/vrbm_ram.sv
src/vrbm_div.sv
src/variable_radius_box_mean.sv
test/tb.sv
